// ===== hdl/fdz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdz_pkg: shared types and constants of the fuzzy defuzzifier
// Field widths, register indexes, method codes and output saturation.
// ----------------------------------------------------------------------------
package fdz_pkg;

    localparam int MEMB_W      = 16;
    localparam int START_W     = 16;
    localparam int STEP_W      = 10;
    localparam int METHOD_W    = 2;
    localparam int CRISP_W     = 22;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_STEP  = 2'd2;

    typedef enum logic [METHOD_W-1:0] {
        METH_CENTROID  = 2'd0,
        METH_MEAN_MAX  = 2'd1,
        METH_LAST_MAX  = 2'd2,
        METH_FIRST_MAX = 2'd3
    } method_t;

    typedef struct packed {
        method_t                    method;
        logic signed [START_W-1:0]  pos_start;
        logic        [STEP_W-1:0]   pos_step;
    } cfg_t;

    localparam logic signed [63:0] CRISP_MAX = 64'sd2097151;
    localparam logic signed [63:0] CRISP_MIN = -64'sd2097152;

    // clamp a wide signed value to the output range
    function automatic logic signed [CRISP_W-1:0] sat_crisp(input logic signed [63:0] v);
        logic signed [CRISP_W-1:0] r;
        if (v > CRISP_MAX) begin
            r = CRISP_MAX[CRISP_W-1:0];
        end else if (v < CRISP_MIN) begin
            r = CRISP_MIN[CRISP_W-1:0];
        end else begin
            r = v[CRISP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/fdz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdz_front: sample intake
// Holds the configuration registers, numbers the samples of a set and works
// out each sample's position before handing it to the queue.
// ----------------------------------------------------------------------------
module fdz_front #(
    parameter  int MAX_POINTS = 1024,
    localparam int IDX_W      = $clog2(MAX_POINTS),
    localparam int POS_W      = IDX_W + fdz_pkg::STEP_W + 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdz_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fdz_pkg::MEMB_W-1:0]       s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             q_full,
    output logic                             q_push,
    output fdz_pkg::cfg_t                    q_cfg,
    output logic [fdz_pkg::MEMB_W-1:0]       q_memb,
    output logic                             q_last,
    output logic                             q_accum,
    output logic [IDX_W-1:0]                 q_idx,
    output logic signed [POS_W-1:0]          q_pos
);
    import fdz_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam int PRD_W = IDX_W + STEP_W;

    cfg_t               cfg_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               accept;
    logic               in_range;
    logic [PRD_W-1:0]   offset;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign in_range      = (idx_reg != CNT_W'(MAX_POINTS));
    assign offset        = PRD_W'(idx_reg[IDX_W-1:0]) * PRD_W'(cfg_reg.pos_step);

    assign q_push  = accept;
    assign q_cfg   = cfg_reg;
    assign q_memb  = s_axis_tdata;
    assign q_last  = s_axis_tlast;
    assign q_accum = in_range;
    assign q_idx   = idx_reg[IDX_W-1:0];
    assign q_pos   = POS_W'(cfg_reg.pos_start) + $signed({2'b00, offset});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.method    <= METH_CENTROID;
            cfg_reg.pos_start <= '0;
            cfg_reg.pos_step  <= STEP_W'(1);
            idx_reg           <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_METHOD:    cfg_reg.method    <= method_t'(cfg_data[METHOD_W-1:0]);
                    REG_POS_START: cfg_reg.pos_start <= cfg_data[START_W-1:0];
                    REG_POS_STEP:  cfg_reg.pos_step  <= cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (s_axis_tlast) begin
                    idx_reg <= '0;
                end else if (in_range) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/fdz_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdz_queue: short word queue between intake and accumulation
// Register-based FIFO of fixed depth with full and empty flags.
// ----------------------------------------------------------------------------
module fdz_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import fdz_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (PTR_W+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (PTR_W+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== hdl/fdz_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdz_divider: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module fdz_divider #(
    parameter int N_W = 50,
    parameter int D_W = 27
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [N_W-1:0] dividend,
    input  logic [D_W-1:0]        divisor,
    output logic                  done,
    output logic signed [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [N_W-1:0]        num_reg;
    logic [D_W-1:0]        den_reg;
    logic [D_W-1:0]        rem_reg;
    logic signed [N_W-1:0] quo_reg;
    logic [D_W:0]          trial;
    logic [D_W:0]          diff;
    logic                  fits;

    assign trial    = {rem_reg, num_reg[N_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
                neg_reg  <= dividend[N_W-1];
                num_reg  <= dividend[N_W-1] ? ($unsigned(~dividend) + N_W'(1))
                                            : $unsigned(dividend);
                den_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo_reg  <= neg_reg ? $signed(N_W'(0) - num_reg) : $signed(num_reg);
                end else begin
                    rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
                    num_reg <= {num_reg[N_W-2:0], fits};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/fdz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdz_back: accumulation and result sequencer
// Pulls samples from the queue, keeps the set's sums and peak tracking, and
// on the last sample forms the crisp value into the output register.
// ----------------------------------------------------------------------------
module fdz_back #(
    parameter  int MAX_POINTS = 1024,
    localparam int IDX_W      = $clog2(MAX_POINTS),
    localparam int POS_W      = IDX_W + fdz_pkg::STEP_W + 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  fdz_pkg::cfg_t                     q_cfg,
    input  logic [fdz_pkg::MEMB_W-1:0]        q_memb,
    input  logic                              q_last,
    input  logic                              q_accum,
    input  logic [IDX_W-1:0]                  q_idx,
    input  logic signed [POS_W-1:0]           q_pos,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fdz_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output logic [0:0]                        m_axis_tuser
);
    import fdz_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam int PRD_W = POS_W + MEMB_W + 1;
    localparam int WS_W  = PRD_W + IDX_W + 1;
    localparam int WT_W  = MEMB_W + IDX_W + 1;
    localparam int PS_W  = POS_W + IDX_W + 1;
    localparam int OFF_W = IDX_W + STEP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    cfg_t                       ent_cfg_reg;
    logic [MEMB_W-1:0]          ent_memb_reg;
    logic                       ent_last_reg;
    logic                       ent_accum_reg;
    logic [IDX_W-1:0]           ent_idx_reg;
    logic signed [POS_W-1:0]    ent_pos_reg;
    logic signed [PRD_W-1:0]    prod_reg;
    logic signed [WS_W-1:0]     wsum_reg;
    logic [WT_W-1:0]            wt_reg;
    logic [MEMB_W-1:0]          peak_reg;
    logic [IDX_W-1:0]           first_idx_reg;
    logic [IDX_W-1:0]           last_idx_reg;
    logic [CNT_W-1:0]           pcnt_reg;
    logic signed [PS_W-1:0]     psum_reg;
    logic signed [CRISP_W-1:0]  res_reg;
    logic                       res_empty_reg;
    logic                       m_valid_reg;
    logic signed [CRISP_W-1:0]  m_data_reg;
    logic                       m_user_reg;

    logic                       set_empty;
    logic                       use_div;
    logic [IDX_W-1:0]           fin_idx;
    logic [OFF_W-1:0]           fin_off;
    logic signed [POS_W-1:0]    fin_pos;
    logic                       div_start;
    logic signed [WS_W-1:0]     div_dividend;
    logic [WT_W-1:0]            div_divisor;
    logic                       div_done;
    logic signed [WS_W-1:0]     div_quotient;
    logic                       out_free;

    assign set_empty = (wt_reg == '0) || (pcnt_reg == '0);
    assign use_div   = (ent_cfg_reg.method == METH_CENTROID)
                    || (ent_cfg_reg.method == METH_MEAN_MAX);
    assign fin_idx   = (ent_cfg_reg.method == METH_LAST_MAX) ? last_idx_reg : first_idx_reg;
    assign fin_off   = OFF_W'(fin_idx) * OFF_W'(ent_cfg_reg.pos_step);
    assign fin_pos   = POS_W'(ent_cfg_reg.pos_start) + $signed({2'b00, fin_off});

    assign div_start    = (state_reg == ST_FIN) && !set_empty && use_div;
    assign div_dividend = (ent_cfg_reg.method == METH_CENTROID) ? wsum_reg : WS_W'(psum_reg);
    assign div_divisor  = (ent_cfg_reg.method == METH_CENTROID) ? wt_reg : WT_W'(pcnt_reg);

    assign q_pop    = ((state_reg == ST_IDLE) || ((state_reg == ST_ACC) && !ent_last_reg))
                   && !q_empty;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W-CRISP_W){1'b0}}, m_data_reg};
    assign m_axis_tuser  = m_user_reg;

    fdz_divider #(
        .N_W (WS_W),
        .D_W (WT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            wsum_reg    <= '0;
            wt_reg      <= '0;
            pcnt_reg    <= '0;
            psum_reg    <= '0;
            peak_reg    <= '0;
        end else begin
            // drop the word once taken, unless a new one loads this cycle
            if (m_axis_tready && !((state_reg == ST_OUT) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                ent_cfg_reg   <= q_cfg;
                ent_memb_reg  <= q_memb;
                ent_last_reg  <= q_last;
                ent_accum_reg <= q_accum;
                ent_idx_reg   <= q_idx;
                ent_pos_reg   <= q_pos;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (ent_accum_reg) begin
                        prod_reg <= PRD_W'($signed({1'b0, ent_memb_reg}))
                                  * PRD_W'(ent_pos_reg);
                        wt_reg   <= wt_reg + WT_W'(ent_memb_reg);
                        if ((pcnt_reg == '0) || (ent_memb_reg > peak_reg)) begin
                            peak_reg      <= ent_memb_reg;
                            first_idx_reg <= ent_idx_reg;
                            last_idx_reg  <= ent_idx_reg;
                            pcnt_reg      <= CNT_W'(1);
                            psum_reg      <= PS_W'(ent_pos_reg);
                        end else if (ent_memb_reg == peak_reg) begin
                            last_idx_reg <= ent_idx_reg;
                            pcnt_reg     <= pcnt_reg + CNT_W'(1);
                            psum_reg     <= psum_reg + PS_W'(ent_pos_reg);
                        end
                    end else begin
                        prod_reg <= '0;
                    end
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    wsum_reg <= wsum_reg + WS_W'(prod_reg);
                    if (ent_last_reg) begin
                        state_reg <= ST_FIN;
                    end else if (q_pop) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    if (set_empty) begin
                        res_reg       <= '0;
                        res_empty_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end else begin
                        res_empty_reg <= 1'b0;
                        if (use_div) begin
                            state_reg <= ST_DIV;
                        end else begin
                            res_reg   <= sat_crisp(64'(fin_pos));
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        res_reg   <= sat_crisp(64'(div_quotient));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        m_user_reg  <= res_empty_reg;
                        wsum_reg    <= '0;
                        wt_reg      <= '0;
                        pcnt_reg    <= '0;
                        psum_reg    <= '0;
                        peak_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/fuzzy_defuzzifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_defuzzifier_unit: streaming fuzzy-set defuzzifier
// Turns a stream of membership samples into one crisp position per set.
// ----------------------------------------------------------------------------
// Feed one fuzzy set as membership words (unsigned Q0.16) on the s_axis side,
// one word per point, with s_axis_tlast on the final point; point i sits at
// pos_start + i*pos_step. The set's result leaves on m_axis as one word: the
// crisp position (22-bit two's complement, saturated) and an empty flag in
// tuser that is set, with a zero position, when the set had no membership.
// The method register picks centroid, mean of maxima, last or first of
// maxima; a word's position uses pos_start and pos_step as they stand when
// it is accepted, but the method, and pos_start and pos_step for last or
// first of maxima, are taken from the last word. Only the first MAX_POINTS
// words of a set count, later ones are dropped until tlast. The accumulator
// handles each word in a multiply step and then an add step on its single
// multiplier, taking the next word in the add step; a 4-word queue lets
// intake run ahead. Closing a set passes a finish step and, for centroid
// or mean of maxima, the bit-serial divider. The result register lets the
// next set accumulate while a result waits on m_axis_tready.
// ----------------------------------------------------------------------------
module fuzzy_defuzzifier_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel: 0 method, 1 pos_start, 2 pos_step
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fdz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fdz_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fdz_pkg::MEMB_W-1:0]        s_axis_tdata,   // [15:0] membership
    input  logic                              s_axis_tlast,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fdz_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,   // [21:0] crisp_value, zero pad
    output logic [0:0]                        m_axis_tuser    // [0] empty_set
);
    import fdz_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int POS_W = IDX_W + STEP_W + 2;
    localparam int ENT_W = $bits(cfg_t) + MEMB_W + 2 + IDX_W + POS_W;

    // intake side of the queue
    logic                    q_push;
    logic                    q_full;
    cfg_t                    f_cfg;
    logic [MEMB_W-1:0]       f_memb;
    logic                    f_last;
    logic                    f_accum;
    logic [IDX_W-1:0]        f_idx;
    logic signed [POS_W-1:0] f_pos;
    logic [ENT_W-1:0]        q_wdata;

    // accumulator side of the queue
    logic                    q_pop;
    logic                    q_empty;
    logic [ENT_W-1:0]        q_rdata;
    cfg_t                    b_cfg;
    logic [MEMB_W-1:0]       b_memb;
    logic                    b_last;
    logic                    b_accum;
    logic [IDX_W-1:0]        b_idx;
    logic signed [POS_W-1:0] b_pos;

    // pack one queue word; unpack in the same order
    assign q_wdata = {f_cfg, f_memb, f_last, f_accum, f_idx, f_pos};
    assign {b_cfg, b_memb, b_last, b_accum, b_idx, b_pos} = q_rdata;

    fdz_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cfg         (f_cfg),
        .q_memb        (f_memb),
        .q_last        (f_last),
        .q_accum       (f_accum),
        .q_idx         (f_idx),
        .q_pos         (f_pos)
    );

    fdz_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    fdz_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_cfg         (b_cfg),
        .q_memb        (b_memb),
        .q_last        (b_last),
        .q_accum       (b_accum),
        .q_idx         (b_idx),
        .q_pos         (b_pos),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // the accumulator only pulls words that the queue holds
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // an empty set always reports a zero position
    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == TDATA_OUT_W'(0)))
        else $error("empty set with nonzero crisp value");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for fuzzy_defuzzifier_unit
// Streams fuzzy sets into the unit with random gaps and back-pressure, works
// out each crisp value with a cycle-free model of the four methods or a typed
// table entry, and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    import fdz_pkg::*;

    localparam int MAX_POINTS   = 1024;
    // covers the queued words and the divider, plus slack
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // index 3 selects no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam longint CRISP_TOP    = (longint'(1) << (CRISP_W - 1)) - 1;
    localparam longint CRISP_BOTTOM = -(longint'(1) << (CRISP_W - 1));

    typedef struct packed {
        logic signed [CRISP_W-1:0] crisp;
        logic                      empty;
    } crisp_result_t;

    // one line of the directed part: either a register write or a run of
    // identical samples, the last of which may close the set
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;   // write rows only
        logic [15:0]           value;     // membership, or register data
        logic                  last;
        logic [10:0]           reps;
        logic                  typed;     // take the expected result below
        logic signed [CRISP_W-1:0] crisp;
        logic                  empty;
    } dir_row_t;

    localparam int DIR_ROWS = 36;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    cfg_data      = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [MEMB_W-1:0]        s_axis_tdata  = '0;   // [15:0] membership
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]   m_axis_tdata;         // [21:0] crisp_value, zero pad
    logic [0:0]               m_axis_tuser;         // [0] empty_set

    // results still owed by the unit, oldest first
    crisp_result_t awaited_results [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    // high during the stretch where neither side idles
    bit            steady         = 1'b0;

    // register shadow, as the unit should hold it
    method_t                   cur_method = METH_CENTROID;
    logic signed [START_W-1:0] cur_start  = '0;
    logic [STEP_W-1:0]         cur_step   = 10'd1;

    // accumulation of the open set
    int     pt_idx    = 0;
    longint wsum      = 0;
    longint msum      = 0;
    logic [MEMB_W-1:0] peak = '0;
    int     first_pk  = 0;
    int     last_pk   = 0;
    int     pk_cnt    = 0;
    longint pk_possum = 0;

    dir_row_t dir_table [DIR_ROWS];

    fuzzy_defuzzifier_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // position of point idx under the current pos_start and pos_step
    function automatic longint point_pos(input int idx);
        return longint'(cur_start) + longint'(idx) * longint'(cur_step);
    endfunction

    // fold one accepted sample into the open set; on the closing sample
    // produce the crisp value and start a fresh set
    task automatic fold_sample(input logic [MEMB_W-1:0] memb, input bit last,
                               output bit produced, output crisp_result_t res);
        longint pos;
        longint crisp;
        produced = 1'b0;
        res      = '0;
        crisp    = 0;
        // samples past the point limit are dropped, the index holds
        if (pt_idx < MAX_POINTS) begin
            pos  = point_pos(pt_idx);
            wsum += longint'(memb) * pos;
            msum += longint'(memb);
            if (pk_cnt == 0 || memb > peak) begin
                peak      = memb;
                first_pk  = pt_idx;
                last_pk   = pt_idx;
                pk_cnt    = 1;
                pk_possum = pos;
            end else if (memb == peak) begin
                last_pk   = pt_idx;
                pk_cnt++;
                pk_possum += pos;
            end
            pt_idx++;
        end
        if (last) begin
            if (msum == 0 || pk_cnt == 0) begin
                res.empty = 1'b1;
            end else begin
                // SV division on signed operands truncates toward zero
                case (cur_method)
                    METH_CENTROID: crisp = wsum / msum;
                    METH_MEAN_MAX: crisp = pk_possum / longint'(pk_cnt);
                    METH_LAST_MAX: crisp = point_pos(last_pk);
                    default:       crisp = point_pos(first_pk);
                endcase
            end
            if (crisp > CRISP_TOP) crisp = CRISP_TOP;
            if (crisp < CRISP_BOTTOM) crisp = CRISP_BOTTOM;
            res.crisp = crisp[CRISP_W-1:0];
            produced  = 1'b1;
            pt_idx    = 0;
            wsum      = 0;
            msum      = 0;
            peak      = '0;
            first_pk  = 0;
            last_pk   = 0;
            pk_cnt    = 0;
            pk_possum = 0;
        end
    endtask

    // present one sample word, hold it until accepted, then predict;
    // a typed expectation replaces the predicted one on a closing sample
    task automatic push_sample(input logic [MEMB_W-1:0] memb, input bit last,
                               input bit typed, input logic signed [CRISP_W-1:0] t_crisp,
                               input bit t_empty);
        crisp_result_t res;
        bit            produced;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= memb;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        fold_sample(memb, last, produced, res);
        if (produced) begin
            if (typed) begin
                res.crisp = t_crisp;
                res.empty = t_empty;
            end
            awaited_results.push_back(res);
        end
    endtask

    // drop the sample stream, wait for every owed result, then let the
    // queue and divider run dry
    task automatic settle_block();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write; the unit must be idle when this is called
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_METHOD:    cur_method = method_t'(data[METHOD_W-1:0]);
            REG_POS_START: cur_start  = data;
            REG_POS_STEP:  cur_step   = data[STEP_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // register data with a bias toward the range ends
    function automatic logic [CFG_DATA_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        case (idx)
            REG_METHOD: v = 16'($urandom_range(3));
            REG_POS_START: begin
                case ($urandom_range(3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    default: v = 16'($urandom);
                endcase
            end
            default: begin
                case ($urandom_range(3))
                    0:       v = 16'd0;
                    1:       v = 16'd1023;
                    default: v = 16'($urandom_range(1023));
                endcase
            end
        endcase
        return v;
    endfunction

    // back-pressure on the result side
    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 21);
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge aclk) begin
        crisp_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result word: crisp_value %0d, empty_set %0d",
                       $signed(m_axis_tdata[CRISP_W-1:0]), m_axis_tuser[0]);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[CRISP_W-1:0] !== want.crisp) begin
                    $error("crisp_value mismatch: expected %0d, actual %0d",
                           want.crisp, $signed(m_axis_tdata[CRISP_W-1:0]));
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.empty) begin
                    $error("empty_set mismatch: expected %0d, actual %0d",
                           want.empty, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          r;
        int          n;
        int          k;
        int          rand_items;
        int          sets_left;
        int          set_len;
        int          style;
        int          mid_at;
        logic [15:0] level;
        logic [15:0] memb;

        //           write  register       value                 last  reps     typed crisp          empty
        dir_table = '{
            // after reset: an all-zero set is empty, a lone peak sits at 0
            '{1'b0, REG_METHOD,    16'd0,                1'b1, 11'd1,    1'b1, 22'sd0,         1'b1},
            '{1'b0, REG_METHOD,    16'd65535,            1'b1, 11'd1,    1'b1, 22'sd0,         1'b0},
            // centroid over a ramp
            '{1'b0, REG_METHOD,    16'd100,              1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd200,              1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd300,              1'b1, 11'd1,    1'b0, 22'sd0,         1'b0},
            // mean of three equal peaks at 0, 1, 2
            '{1'b1, REG_METHOD,    16'(METH_MEAN_MAX),   1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd65535,            1'b1, 11'd3,    1'b1, 22'sd1,         1'b0},
            // most negative start, widest step, last of four equal peaks
            '{1'b1, REG_POS_START, 16'h8000,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd1023,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_METHOD,    16'(METH_LAST_MAX),   1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd65535,            1'b1, 11'd4,    1'b1, -22'sd29699,    1'b0},
            // first of two separated peaks
            '{1'b1, REG_METHOD,    16'(METH_FIRST_MAX),  1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd1,                1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd65535,            1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd7,                1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd65535,            1'b1, 11'd1,    1'b1, -22'sd31745,    1'b0},
            // empty set under first of maxima, largest start, zero step
            '{1'b1, REG_POS_START, 16'h7FFF,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd0,                1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd0,                1'b1, 11'd2,    1'b1, 22'sd0,         1'b1},
            // mean of maxima at -3 and -2 truncates toward zero
            '{1'b1, REG_METHOD,    16'(METH_MEAN_MAX),   1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_START, 16'hFFFD,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd1,                1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd9,                1'b1, 11'd2,    1'b1, -22'sd2,        1'b0},
            // write to the unused index: nothing changes
            '{1'b1, REG_NONE,      16'hFFFF,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            // over-long set: points past the limit are dropped
            '{1'b1, REG_METHOD,    16'(METH_CENTROID),   1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_START, 16'h7FFF,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd1023,             1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd65535,            1'b1, 11'd1030, 1'b0, 22'sd0,         1'b0},
            // step changes in the middle of a set
            '{1'b1, REG_POS_START, 16'd0,                1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd1,                1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd1000,             1'b0, 11'd3,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_POS_STEP,  16'd100,              1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd1000,             1'b1, 11'd1,    1'b0, 22'sd0,         1'b0},
            // method changes in the middle of a set: the closing word decides
            '{1'b0, REG_METHOD,    16'd500,              1'b0, 11'd1,    1'b0, 22'sd0,         1'b0},
            '{1'b1, REG_METHOD,    16'(METH_LAST_MAX),   1'b0, 11'd0,    1'b0, 22'sd0,         1'b0},
            '{1'b0, REG_METHOD,    16'd500,              1'b1, 11'd1,    1'b0, 22'sd0,         1'b0}
        };

        // hold reset, then release it off the active edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part: walk the table
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].is_write) begin
                settle_block();
                write_register(dir_table[r].reg_idx, dir_table[r].value);
            end else begin
                for (n = 1; n <= dir_table[r].reps; n++) begin
                    push_sample(dir_table[r].value, dir_table[r].last && (n == dir_table[r].reps),
                                dir_table[r].typed, dir_table[r].crisp, dir_table[r].empty);
                end
            end
        end

        // random part: phases of register settings, each with a batch of sets
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle_block();
            if ($urandom_range(9) < 6) write_register(REG_METHOD, random_reg_value(REG_METHOD));
            if ($urandom_range(9) < 6) begin
                write_register(REG_POS_START, random_reg_value(REG_POS_START));
            end
            if ($urandom_range(9) < 6) begin
                write_register(REG_POS_STEP, random_reg_value(REG_POS_STEP));
            end
            sets_left = $urandom_range(4, 16);
            while (sets_left > 0 && rand_items < RANDOM_ITEMS) begin
                sets_left--;
                // mostly short sets, now and then a longer one
                set_len = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
                style   = $urandom_range(11);
                level   = 16'($urandom);
                // occasionally rewrite a register halfway through the set
                mid_at  = (set_len >= 2 && $urandom_range(15) == 0) ? set_len / 2 : -1;
                for (k = 0; k < set_len; k++) begin
                    if (k == mid_at) begin
                        settle_block();
                        n = $urandom_range(2);
                        write_register(CFG_IDX_W'(n), random_reg_value(CFG_IDX_W'(n)));
                    end
                    case (style)
                        0:       memb = 16'd0;
                        1, 2:    memb = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        // repeated level with lower values around it: ties
                        3, 4, 5, 6: begin
                            memb = ($urandom_range(2) == 0) ? level
                                                            : 16'($urandom_range(level));
                        end
                        default: memb = 16'($urandom);
                    endcase
                    steady = (rand_items >= 200 && rand_items < 450);
                    push_sample(memb, k == set_len - 1, 1'b0, '0, 1'b0);
                    rand_items++;
                end
            end
        end
        steady = 1'b0;

        // wait for every owed result, then a little longer for strays
        settle_block();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
